// ===== sv/edfw_pkg.sv =====
// ----------------------------------------------------------------------------
// Earliest-free-worker dispatch package
// Shared field widths, defaults, the controller state type and the command
// and status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package edfw_pkg;

    // Default sizing of the worker pool and of the free-time word.
    localparam int DEF_MAX_WORKERS = 16;
    localparam int DEF_TIME_BITS   = 48;

    // Fixed field widths on the ports.
    localparam int DUR_W      = 32;
    localparam int CFG_W      = 5;
    localparam int IDX_FLD_W  = 4;
    localparam int START_FLD_W = 48;
    localparam int M_TDATA_W  = 56;
    localparam int M_PAD_W    = M_TDATA_W - IDX_FLD_W - START_FLD_W - 1;

    // Reset value of the worker count register.
    localparam logic [CFG_W-1:0] NUM_WORKERS_RST = CFG_W'(1);

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_UPDATE,
        ST_HOLD
    } edfw_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_wr;   // write zero at the scan address
        logic load_item;  // capture the job and restart the address counter
        logic addr_inc;   // advance the address counter
        logic rd_en;      // read the free time at the scan address
        logic update;     // write back the chosen worker's new free time
        logic load_out;   // load the result into the output register
    } edfw_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_end;  // address counter is on the last entry of the store
        logic scan_end;   // address counter is on the last active worker
        logic out_free;   // output register can take a result this cycle
    } edfw_status_t;

endpackage

// ===== sv/edfw_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edfw_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/edfw_dp.sv =====
// ----------------------------------------------------------------------------
// Earliest-free-worker dispatch datapath
// Holds the worker count, the free-time store, the running minimum of the
// scan, the saturating update and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edfw_dp #(
    parameter int MAX_WORKERS = edfw_pkg::DEF_MAX_WORKERS,
    parameter int TIME_BITS   = edfw_pkg::DEF_TIME_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  edfw_pkg::edfw_cmd_t            cmd,
    output edfw_pkg::edfw_status_t         status,
    input  logic                           cfg_valid,
    input  logic [edfw_pkg::CFG_W-1:0]     cfg_data,
    input  logic [edfw_pkg::DUR_W-1:0]     s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [edfw_pkg::M_TDATA_W-1:0] m_tdata
);

    import edfw_pkg::*;

    localparam int IDX_W   = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int SUM_W   = ((TIME_BITS > DUR_W) ? TIME_BITS : DUR_W) + 1;
    localparam int START_W = (TIME_BITS > START_FLD_W) ? TIME_BITS : START_FLD_W;
    localparam int IDXO_W  = (IDX_W > IDX_FLD_W) ? IDX_W : IDX_FLD_W;

    logic [CFG_W-1:0]       num_workers_reg;
    logic [DUR_W-1:0]       dur_reg;
    logic [IDX_W-1:0]       addr_reg;
    logic                   rd_vld_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic [IDX_W-1:0]       best_idx_reg;
    logic [TIME_BITS-1:0]   best_time_reg;
    logic                   m_valid_reg;
    logic [IDX_FLD_W-1:0]   idx_out_reg;
    logic [START_FLD_W-1:0] start_out_reg;
    logic                   ovf_out_reg;

    logic [IDX_W-1:0]       last_idx;
    logic [TIME_BITS-1:0]   rd_data;
    logic                   take;
    logic [SUM_W-1:0]       sum;
    logic                   ovf;
    logic [TIME_BITS-1:0]   new_time;
    logic [START_W-1:0]     start_wide;
    logic [IDXO_W-1:0]      idx_wide;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [TIME_BITS-1:0]   wr_data;

    // Worker count register; written whenever the configuration channel
    // offers a transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_workers_reg <= NUM_WORKERS_RST;
        end else if (cfg_valid) begin
            num_workers_reg <= cfg_data;
        end
    end

    // Index of the last active worker: a count of zero acts as one worker and
    // a count above the pool size acts as the full pool.
    always_comb begin
        if (num_workers_reg == '0) begin
            last_idx = '0;
        end else if (32'(num_workers_reg) > 32'(MAX_WORKERS)) begin
            last_idx = IDX_W'(MAX_WORKERS - 1);
        end else begin
            last_idx = IDX_W'(num_workers_reg - CFG_W'(1));
        end
    end

    // Address counter shared by the clearing pass and the scan.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg <= '0;
        end else if (cmd.load_item) begin
            addr_reg <= '0;
        end else if (cmd.addr_inc) begin
            addr_reg <= addr_reg + IDX_W'(1);
        end
    end

    // Job capture.
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            dur_reg <= s_tdata;
        end
    end

    // Read tracking: which worker the read data belongs to.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_idx_reg <= addr_reg;
        end
    end

    // Running minimum; a strict compare keeps the lowest index on a tie.
    assign take = rd_vld_reg && ((rd_idx_reg == '0) || (rd_data < best_time_reg));

    always_ff @(posedge aclk) begin
        if (take) begin
            best_idx_reg  <= rd_idx_reg;
            best_time_reg <= rd_data;
        end
    end

    // Saturating update of the chosen worker's free time.
    assign sum      = SUM_W'(best_time_reg) + SUM_W'(dur_reg);
    assign ovf      = |sum[SUM_W-1:TIME_BITS];
    assign new_time = ovf ? '1 : sum[TIME_BITS-1:0];

    // Free-time store port selection.
    assign wr_en   = cmd.clear_wr || cmd.update;
    assign wr_addr = cmd.update ? best_idx_reg : addr_reg;
    assign wr_data = cmd.update ? new_time : '0;

    edfw_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (MAX_WORKERS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    // Result fields at their port widths.
    assign start_wide = START_W'(best_time_reg);
    assign idx_wide   = IDXO_W'(best_idx_reg);

    // Output register: valid is cleared by a transfer unless a new result
    // replaces it in the same cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            idx_out_reg   <= idx_wide[IDX_FLD_W-1:0];
            start_out_reg <= start_wide[START_FLD_W-1:0];
            ovf_out_reg   <= ovf;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {M_PAD_W'(0), ovf_out_reg, start_out_reg, idx_out_reg};

    // Status to the controller.
    assign status.clear_end = (addr_reg == IDX_W'(MAX_WORKERS - 1));
    assign status.scan_end  = (addr_reg == last_idx);
    assign status.out_free  = !m_valid_reg || m_tready;

endmodule

// ===== sv/edfw_ctrl.sv =====
// ----------------------------------------------------------------------------
// Earliest-free-worker dispatch controller
// Sequences the clearing pass, the scan over the active workers, the
// write-back and the hand-off of each result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edfw_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  edfw_pkg::edfw_status_t status,
    output edfw_pkg::edfw_cmd_t    cmd
);

    import edfw_pkg::*;

    edfw_state_t state_reg;
    edfw_state_t state_next;

    // State register; reset starts the clearing pass.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (status.clear_end) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.scan_end) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                state_next = status.out_free ? ST_IDLE : ST_HOLD;
            end
            ST_HOLD: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Output logic.
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                cmd.addr_inc = 1'b1;
            end
            ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.load_item = s_tvalid;
            end
            ST_SCAN: begin
                cmd.rd_en    = 1'b1;
                cmd.addr_inc = 1'b1;
            end
            ST_LAST: begin
                cmd = '0;
            end
            ST_UPDATE: begin
                cmd.update   = 1'b1;
                cmd.load_out = status.out_free;
            end
            ST_HOLD: begin
                cmd.load_out = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== sv/earliest_free_worker_dispatch.sv =====
// ----------------------------------------------------------------------------
// Earliest-free-worker dispatch
// Each job scans the N active workers, where N is the active worker count,
// reading one free time per cycle from the RAM; a new job is taken only once
// the previous result has been loaded into the output register.
// Reset: a clearing pass zeroes all MAX_WORKERS free times; no job
// is taken meanwhile, configuration writes are.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module earliest_free_worker_dispatch #(
    parameter int MAX_WORKERS = edfw_pkg::DEF_MAX_WORKERS,
    parameter int TIME_BITS   = edfw_pkg::DEF_TIME_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration: num_workers[4:0]
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [edfw_pkg::CFG_W-1:0]     cfg_data,
    // Input tdata: duration[31:0]
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [edfw_pkg::DUR_W-1:0]     s_tdata,
    // Output tdata: worker_index[3:0], start_time[51:4], overflow[52], zero[55:53]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [edfw_pkg::M_TDATA_W-1:0] m_tdata
);

    import edfw_pkg::*;

    edfw_cmd_t    cmd;
    edfw_status_t status;

    // The worker count register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    edfw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    edfw_dp #(
        .MAX_WORKERS (MAX_WORKERS),
        .TIME_BITS   (TIME_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== sv/edfw_checker.sv =====
// ----------------------------------------------------------------------------
// Earliest-free-worker dispatch checker
// Port-level properties of the dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edfw_checker #(
    parameter int MAX_WORKERS = edfw_pkg::DEF_MAX_WORKERS
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [edfw_pkg::M_TDATA_W-1:0] m_tdata
);

    import edfw_pkg::*;

    // Reset starts the clearing pass with no result pending.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> (!s_tready && !m_tvalid))
        else $error("no clearing pass or stale result after reset");

    // Only one job is in flight: an input transfer closes the input side.
    a_one_job: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a job is in progress");

    // A result is not raised right after its input transfer; the scan lies between.
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result appeared right after an input transfer");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed or dropped");

    // The chosen worker lies inside the pool.
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (32'(m_tdata[IDX_FLD_W-1:0]) < 32'(MAX_WORKERS)))
        else $error("worker index beyond the pool");

endmodule

bind earliest_free_worker_dispatch edfw_checker #(
    .MAX_WORKERS (MAX_WORKERS)
) u_edfw_checker (.*);

// ===== tb/sv/earliest_free_worker_dispatch_tb.sv =====
// ----------------------------------------------------------------------------
// Earliest-free-worker dispatch testbench
// Streams job durations into the dispatcher and checks each result transfer
// (worker index, start time, overflow) against a local scoreboard of worker
// free times. A short directed table covers reset, worker-count extremes and
// ties. Random jobs follow under changing worker counts and idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module earliest_free_worker_dispatch_tb;

    localparam int MAX_W        = edfw_pkg::DEF_MAX_WORKERS;
    localparam int TB_TIME_W    = edfw_pkg::DEF_TIME_BITS;
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int HOLD_LEN     = 400;
    localparam logic [TB_TIME_W-1:0] TIME_TOP = '1;

    // One dispatch decision as it appears on the result channel.
    typedef struct packed {
        logic [edfw_pkg::IDX_FLD_W-1:0]   worker;
        logic [edfw_pkg::START_FLD_W-1:0] start;
        logic                             ovf;
    } dispatch_t;

    typedef enum logic {
        ROW_JOB,
        ROW_CFG
    } row_kind_t;

    // One line of the directed script.
    typedef struct {
        row_kind_t kind;
        logic [31:0] value;
        bit typed;
        dispatch_t result;
    } script_row_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [edfw_pkg::CFG_W-1:0]     cfg_data;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [edfw_pkg::DUR_W-1:0]     s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [edfw_pkg::M_TDATA_W-1:0] m_tdata;

    // Scoreboard copy of the worker state and the worker-count register.
    logic [TB_TIME_W-1:0]       free_at [MAX_W];
    logic [edfw_pkg::CFG_W-1:0] worker_cfg;

    dispatch_t   pending[$];
    script_row_t script[$];

    int          err_cnt     = 0;
    int unsigned cycle_cnt   = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          hold_req    = 0;

    earliest_free_worker_dispatch uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Free-running clock, 12 ns period.
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Hard stop if the run hangs.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Picks the earliest-free active worker and books the job on it.
    function automatic dispatch_t assign_job(input logic [31:0] dur);
        int unsigned n;
        int unsigned best;
        int unsigned j;
        logic [TB_TIME_W:0] sum;
        dispatch_t r;
        n = 32'(worker_cfg);
        if (n == 0)
            n = 1;
        if (n > MAX_W)
            n = MAX_W;
        best = 0;
        for (j = 1; j < n; j++) begin
            if (free_at[j] < free_at[best])
                best = j;
        end
        sum = {1'b0, free_at[best]} + {{(TB_TIME_W + 1 - 32){1'b0}}, dur};
        r.worker = best[edfw_pkg::IDX_FLD_W-1:0];
        r.start  = free_at[best];
        r.ovf    = 1'b0;
        if (sum > {1'b0, TIME_TOP}) begin
            sum   = {1'b0, TIME_TOP};
            r.ovf = 1'b1;
        end
        free_at[best] = sum[TB_TIME_W-1:0];
        return r;
    endfunction

    function automatic void report(input string name, input logic [63:0] want,
                                   input logic [63:0] got);
        err_cnt++;
        $error("%s: expected %0h, actual %0h", name, want, got);
    endfunction

    // Offers one job and books it once the transfer happens. The valid is
    // left high; the caller either offers the next job or lowers it.
    task automatic send_job(input logic [31:0] dur, input bit typed,
                            input dispatch_t typed_res);
        dispatch_t r;
        s_tvalid <= 1'b1;
        s_tdata  <= dur;
        do @(posedge aclk); while (!s_tready);
        r = assign_job(dur);
        pending.push_back(typed ? typed_res : r);
    endtask

    // Lets all booked jobs come back before touching the register.
    task automatic drain_results;
        while (pending.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_workers(input logic [edfw_pkg::CFG_W-1:0] v);
        s_tvalid <= 1'b0;
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        worker_cfg = v;
    endtask

    task automatic add_row(input row_kind_t kind, input logic [31:0] value,
                           input bit typed, input logic [3:0] worker,
                           input logic [47:0] start, input logic ovf);
        script_row_t r;
        r.kind          = kind;
        r.value         = value;
        r.typed         = typed;
        r.result.worker = worker;
        r.result.start  = start;
        r.result.ovf    = ovf;
        script.push_back(r);
    endtask

    // Mostly short jobs, with full-range and edge durations mixed in.
    function automatic logic [31:0] pick_duration;
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 40)
            return $urandom_range(31);
        else if (roll < 70)
            return $urandom_range(65535);
        else if (roll < 90)
            return $urandom;
        else if (roll < 95)
            return 32'h0;
        else
            return 32'hFFFF_FFFF;
    endfunction

    function automatic logic [edfw_pkg::CFG_W-1:0] pick_workers;
        int unsigned roll;
        roll = $urandom_range(99);
        case ($urandom_range(3))
            0: pick_workers = 5'd0;
            1: pick_workers = 5'd1;
            2: pick_workers = 5'd16;
            default: pick_workers = 5'd31;
        endcase
        if (roll >= 30)
            pick_workers = 5'($urandom_range(31));
    endfunction

    // Random jobs with a new worker count every few dozen transfers.
    task automatic run_random(input int count, input bit with_hold);
        int i;
        int seg;
        seg = 0;
        for (i = 0; i < count; i++) begin
            if (seg == 0) begin
                write_workers(pick_workers());
                seg = $urandom_range(40, 90);
            end
            seg--;
            if (with_hold && i == count / 3)
                hold_req++;
            if ($urandom_range(99) < tx_idle_pct) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end
            send_job(pick_duration(), 1'b0, '0);
        end
    endtask

    // Result side: random back-pressure, plus long holds on request.
    initial begin : result_ready
        int hold_ack;
        int hold_left;
        hold_ack  = 0;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req != hold_ack) begin
                hold_ack  = hold_req;
                hold_left = HOLD_LEN;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Compare each result transfer with the oldest booked job.
    always @(posedge aclk) begin : check_results
        dispatch_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending.size() == 0) begin
                report("unexpected result", 64'h0, 64'(m_tdata));
            end else begin
                want = pending.pop_front();
                if (m_tdata[3:0] !== want.worker)
                    report("worker_index", 64'(want.worker), 64'(m_tdata[3:0]));
                if (m_tdata[51:4] !== want.start)
                    report("start_time", 64'(want.start), 64'(m_tdata[51:4]));
                if (m_tdata[52] !== want.ovf)
                    report("overflow", 64'(want.ovf), 64'(m_tdata[52]));
                if (m_tdata[55:53] !== 3'b000)
                    report("pad", 64'h0, 64'(m_tdata[55:53]));
            end
        end
    end

    initial begin : stimulus
        int k;
        int p;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        aresetn   <= 1'b0;
        for (k = 0; k < MAX_W; k++)
            free_at[k] = '0;
        worker_cfg = edfw_pkg::NUM_WORKERS_RST;

        // Directed script; typed results are the ones obvious from reset state.
        add_row(ROW_JOB, 32'h0,         1, 4'd0, 48'h0,           1'b0);
        add_row(ROW_JOB, 32'hFFFF_FFFF, 1, 4'd0, 48'h0,           1'b0);
        add_row(ROW_JOB, 32'h1,         1, 4'd0, 48'hFFFF_FFFF,   1'b0);
        // A worker count of zero behaves as one worker.
        add_row(ROW_CFG, 32'd0,         0, 4'd0, 48'h0,           1'b0);
        add_row(ROW_JOB, 32'h7,         1, 4'd0, 48'h1_0000_0000, 1'b0);
        // Full pool: idle workers tie at zero, lowest index wins.
        add_row(ROW_CFG, 32'd16,        0, 4'd0, 48'h0,           1'b0);
        add_row(ROW_JOB, 32'h10,        1, 4'd1, 48'h0,           1'b0);
        add_row(ROW_JOB, 32'h5,         1, 4'd2, 48'h0,           1'b0);
        add_row(ROW_JOB, 32'h0,         1, 4'd3, 48'h0,           1'b0);
        add_row(ROW_JOB, 32'h3,         1, 4'd3, 48'h0,           1'b0);
        // Counts above the pool size saturate.
        add_row(ROW_CFG, 32'd31,        0, 4'd0, 48'h0,           1'b0);
        add_row(ROW_JOB, 32'hA5A5_A5A5, 1, 4'd4, 48'h0,           1'b0);
        add_row(ROW_JOB, 32'h5A5A_5A5A, 0, 4'd0, 48'h0,           1'b0);
        add_row(ROW_JOB, 32'h2,         0, 4'd0, 48'h0,           1'b0);
        // Shrinking the pool keeps the free times of the dropped workers.
        add_row(ROW_CFG, 32'd2,         0, 4'd0, 48'h0,           1'b0);
        add_row(ROW_JOB, 32'h9,         0, 4'd0, 48'h0,           1'b0);
        add_row(ROW_JOB, 32'h0,         0, 4'd0, 48'h0,           1'b0);
        add_row(ROW_CFG, 32'd17,        0, 4'd0, 48'h0,           1'b0);
        add_row(ROW_JOB, 32'hFFFF_FFFF, 0, 4'd0, 48'h0,           1'b0);
        add_row(ROW_JOB, 32'hFFFF_FFFF, 0, 4'd0, 48'h0,           1'b0);
        add_row(ROW_JOB, 32'h1,         0, 4'd0, 48'h0,           1'b0);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            if (script[i].kind == ROW_CFG)
                write_workers(script[i].value[edfw_pkg::CFG_W-1:0]);
            else
                send_job(script[i].value, script[i].typed, script[i].result);
        end

        // Random phases: sender light / receiver heavy, swapped, then no idling.
        for (p = 0; p < 3; p++) begin
            tx_idle_pct = (p == 0) ? 10 : (p == 1) ? 65 : 0;
            rx_idle_pct = (p == 0) ? 65 : (p == 1) ? 10 : 0;
            run_random(430, p == 0);
        end

        // Sender pauses until every booked job has come back.
        s_tvalid <= 1'b0;
        drain_results();

        repeat (MAX_W + 8) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
